FILE: hdl/cpg_pkg.sv
// Shared widths, types and constants for the corner-point cell geometry block.
// Used by cpg_interp and corner_point_cell_geometry; depends on nothing else.
package cpg_pkg;

   // Coordinate format: signed two's complement with 8 fraction bits.
   localparam int COORD_BITS = 36;
   localparam int MAX_CELLS  = 16777216;

   // Widths derived from the coordinate width.
   localparam int MAG_W  = COORD_BITS + 1;       // magnitude of a coordinate difference
   localparam int LO_W   = (MAG_W + 1) / 2;      // low slice of the multiplier operand
   localparam int HI_W   = MAG_W - LO_W;         // high slice of the multiplier operand
   localparam int PP_W   = LO_W + MAG_W;         // one partial product
   localparam int PROD_W = 2 * MAG_W;            // full product
   localparam int QUO_W  = COORD_BITS + 2;       // quotient bits developed by the divider
   localparam int CNT_W  = $clog2(QUO_W);        // divider step counter
   localparam int RES_W  = COORD_BITS + 3;       // top coordinate plus clamped quotient
   localparam int SUM_W  = COORD_BITS + 3;       // sum of eight corners
   localparam int SLOT_W = 3;                    // corner number within a cell
   localparam int ACT_W  = $clog2(MAX_CELLS) + 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT = {SLOT_W{1'b1}};

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((7 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS = 6 * COORD_BITS + SLOT_W + ACT_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

endpackage

FILE: hdl/cpg_interp.sv
// Iterative interpolation unit: t0 + (z - z0) * (t1 - t0) / (z1 - z0), clamped and saturated.
// Two-slice multiply, then a restoring divider that retires one quotient bit per cycle.
// Depends on cpg_pkg.
module cpg_interp (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cpg_pkg::coord_type t0,
   input  cpg_pkg::coord_type t1,
   input  cpg_pkg::coord_type z0,
   input  cpg_pkg::coord_type z1,
   input  cpg_pkg::coord_type z,
   output logic               done,
   output cpg_pkg::coord_type result
);

   typedef enum logic [8:0] {
      IP_IDLE    = 9'b000000001,
      IP_MAG     = 9'b000000010,
      IP_MUL_LO  = 9'b000000100,
      IP_MUL_HI  = 9'b000001000,
      IP_MUL_ADD = 9'b000010000,
      IP_CHECK   = 9'b000100000,
      IP_DIV     = 9'b001000000,
      IP_SUM     = 9'b010000000,
      IP_SAT     = 9'b100000000
   } ip_state_type;

   localparam logic [cpg_pkg::QUO_W-1:0] QLIM = {1'b1, {(cpg_pkg::QUO_W-1){1'b0}}};

   ip_state_type state_ff, state_in;

   logic signed [cpg_pkg::MAG_W-1:0] num_ff, num_in, dv_ff, dv_in, den_ff, den_in;
   cpg_pkg::coord_type               t0_ff, t0_in;
   logic [cpg_pkg::MAG_W-1:0]        a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic                             neg_ff, neg_in;
   logic [cpg_pkg::PP_W-1:0]         pp_ff, pp_in;
   logic [cpg_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [cpg_pkg::MAG_W-1:0]        rem_ff, rem_in;
   logic [cpg_pkg::QUO_W-1:0]        low_ff, low_in;
   logic [cpg_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [cpg_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             big_ff, big_in;
   logic signed [cpg_pkg::RES_W-1:0] sum_ff, sum_in;
   cpg_pkg::coord_type               result_ff, result_in;
   logic                             done_ff, done_in;

   logic [cpg_pkg::MAG_W:0]          trial;
   logic                             trial_ge;
   logic [cpg_pkg::QUO_W-1:0]        quo_clamped;
   logic signed [cpg_pkg::RES_W-1:0] t0_wide, q_wide;
   logic                             sat_pos, sat_neg;

   always_comb begin
      trial       = {rem_ff, low_ff[cpg_pkg::QUO_W-1]};
      trial_ge    = trial >= {1'b0, d_ff};
      quo_clamped = (big_ff || quo_ff > QLIM) ? QLIM : quo_ff;
      t0_wide     = {{(cpg_pkg::RES_W-cpg_pkg::COORD_BITS){t0_ff[cpg_pkg::COORD_BITS-1]}}, t0_ff};
      q_wide      = $signed({{(cpg_pkg::RES_W-cpg_pkg::QUO_W){1'b0}}, quo_clamped});
      // The result fits when every bit from the coordinate sign upward agrees.
      sat_pos     = !sum_ff[cpg_pkg::RES_W-1] &&
                    (sum_ff[cpg_pkg::RES_W-1:cpg_pkg::COORD_BITS-1] != '0);
      sat_neg     = sum_ff[cpg_pkg::RES_W-1] &&
                    (sum_ff[cpg_pkg::RES_W-1:cpg_pkg::COORD_BITS-1] != '1);
   end

   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      dv_in     = dv_ff;
      den_in    = den_ff;
      t0_in     = t0_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      d_in      = d_ff;
      neg_in    = neg_ff;
      pp_in     = pp_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      low_in    = low_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      big_in    = big_ff;
      sum_in    = sum_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         IP_IDLE: begin
            if (start) begin
               num_in   = {z[cpg_pkg::COORD_BITS-1], z} - {z0[cpg_pkg::COORD_BITS-1], z0};
               dv_in    = {t1[cpg_pkg::COORD_BITS-1], t1} - {t0[cpg_pkg::COORD_BITS-1], t0};
               den_in   = {z1[cpg_pkg::COORD_BITS-1], z1} - {z0[cpg_pkg::COORD_BITS-1], z0};
               t0_in    = t0;
               state_in = IP_MAG;
            end
         end
         IP_MAG: begin
            a_in     = num_ff[cpg_pkg::MAG_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
            b_in     = dv_ff[cpg_pkg::MAG_W-1] ? $unsigned(-dv_ff) : $unsigned(dv_ff);
            d_in     = den_ff[cpg_pkg::MAG_W-1] ? $unsigned(-den_ff) : $unsigned(den_ff);
            neg_in   = num_ff[cpg_pkg::MAG_W-1] ^ dv_ff[cpg_pkg::MAG_W-1] ^
                       den_ff[cpg_pkg::MAG_W-1];
            state_in = IP_MUL_LO;
         end
         IP_MUL_LO: begin
            pp_in    = cpg_pkg::PP_W'(a_ff[cpg_pkg::LO_W-1:0]) * cpg_pkg::PP_W'(b_ff);
            state_in = IP_MUL_HI;
         end
         IP_MUL_HI: begin
            prod_in  = cpg_pkg::PROD_W'(pp_ff);
            pp_in    = cpg_pkg::PP_W'(a_ff[cpg_pkg::MAG_W-1:cpg_pkg::LO_W]) *
                       cpg_pkg::PP_W'(b_ff);
            state_in = IP_MUL_ADD;
         end
         IP_MUL_ADD: begin
            prod_in  = prod_ff + (cpg_pkg::PROD_W'(pp_ff) << cpg_pkg::LO_W);
            state_in = IP_CHECK;
         end
         IP_CHECK: begin
            // If the bits above the quotient field already reach the divisor, the
            // quotient is past the clamp and the division is skipped.
            big_in   = cpg_pkg::MAG_W'(prod_ff[cpg_pkg::PROD_W-1:cpg_pkg::QUO_W]) >= d_ff;
            rem_in   = cpg_pkg::MAG_W'(prod_ff[cpg_pkg::PROD_W-1:cpg_pkg::QUO_W]);
            low_in   = prod_ff[cpg_pkg::QUO_W-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = (cpg_pkg::MAG_W'(prod_ff[cpg_pkg::PROD_W-1:cpg_pkg::QUO_W]) >= d_ff)
                       ? IP_SUM : IP_DIV;
         end
         IP_DIV: begin
            rem_in = trial_ge ? cpg_pkg::MAG_W'(trial - {1'b0, d_ff})
                              : cpg_pkg::MAG_W'(trial);
            quo_in = {quo_ff[cpg_pkg::QUO_W-2:0], trial_ge};
            low_in = {low_ff[cpg_pkg::QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cpg_pkg::CNT_W'(cpg_pkg::QUO_W - 1)) begin
               state_in = IP_SUM;
            end
         end
         IP_SUM: begin
            sum_in   = neg_ff ? t0_wide - q_wide : t0_wide + q_wide;
            state_in = IP_SAT;
         end
         IP_SAT: begin
            if (sat_pos) begin
               result_in = {1'b0, {(cpg_pkg::COORD_BITS-1){1'b1}}};
            end else if (sat_neg) begin
               result_in = {1'b1, {(cpg_pkg::COORD_BITS-1){1'b0}}};
            end else begin
               result_in = sum_ff[cpg_pkg::COORD_BITS-1:0];
            end
            done_in  = 1'b1;
            state_in = IP_IDLE;
         end
         default: begin
            state_in = IP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      dv_ff     <= dv_in;
      den_ff    <= den_in;
      t0_ff     <= t0_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      d_ff      <= d_in;
      neg_ff    <= neg_in;
      pp_ff     <= pp_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      low_ff    <= low_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      big_ff    <= big_in;
      sum_ff    <= sum_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

FILE: hdl/corner_point_cell_geometry.sv
// Corner-point cell geometry: interpolates each corner on its pillar and builds cell centres.
// A flat pillar skips interpolation and goes straight to accumulation; otherwise the
// shared cpg_interp unit runs x then y, each pass paced by its 38-step restoring
// divider (a clamped quotient skips the divider).
// One item is in work at a time; req_tready returns on the edge that registers its result.
// Reset (synchronous, active high) clears the corner slot, the sums and the active counter.
module corner_point_cell_geometry (
   input  logic                              clock,
   input  logic                              reset,
   // Fields from bit 0 up: top_x, top_y, top_z, bottom_x, bottom_y, bottom_z, corner_depth.
   input  logic [cpg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields from bit 0 up: cell_active, grid_start.
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: corner_x, corner_y, corner_z, corner_slot,
   // center_x, center_y, center_z, active_number.
   output logic [cpg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Fields from bit 0 up: flat_pillar.
   output logic [0:0]                        rsp_tuser,
   // cell_done: set on the eighth corner of a cell.
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam int CB = cpg_pkg::COORD_BITS;

   typedef enum logic [4:0] {
      T_IDLE = 5'b00001,
      T_X    = 5'b00010,
      T_Y    = 5'b00100,
      T_ACC  = 5'b01000,
      T_EMIT = 5'b10000
   } top_state_type;

   top_state_type state_ff, state_in;

   cpg_pkg::coord_type top_x_ff, top_x_in, top_y_ff, top_y_in, top_z_ff, top_z_in;
   cpg_pkg::coord_type bot_x_ff, bot_x_in, bot_y_ff, bot_y_in, bot_z_ff, bot_z_in;
   cpg_pkg::coord_type depth_ff, depth_in;
   logic               active_ff, active_in;
   logic               flat_ff, flat_in;
   logic               axis_ff, axis_in;
   logic               start_ff, start_in;
   cpg_pkg::coord_type cx_ff, cx_in, cy_ff, cy_in;

   logic [cpg_pkg::SLOT_W-1:0] slot_ff, slot_in;
   cpg_pkg::sum_type           sum_x_ff, sum_x_in, sum_y_ff, sum_y_in, sum_z_ff, sum_z_in;
   logic [cpg_pkg::ACT_W-1:0]  act_ff, act_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cpg_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_flat_ff, rsp_flat_in;
   logic                       rsp_last_ff, rsp_last_in;

   cpg_pkg::coord_type ip_t0, ip_t1, ip_result;
   logic               ip_done;

   cpg_pkg::coord_type in_tx, in_ty, in_tz, in_bx, in_by, in_bz, in_cz;
   logic               req_take;
   logic               cell_last;
   cpg_pkg::coord_type cen_x, cen_y, cen_z;
   logic [cpg_pkg::ACT_W-1:0] act_number;

   assign in_tx = req_tdata[CB-1:0];
   assign in_ty = req_tdata[2*CB-1:CB];
   assign in_tz = req_tdata[3*CB-1:2*CB];
   assign in_bx = req_tdata[4*CB-1:3*CB];
   assign in_by = req_tdata[5*CB-1:4*CB];
   assign in_bz = req_tdata[6*CB-1:5*CB];
   assign in_cz = req_tdata[7*CB-1:6*CB];

   assign req_tready = (state_ff == T_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign ip_t0 = axis_ff ? top_y_ff : top_x_ff;
   assign ip_t1 = axis_ff ? bot_y_ff : bot_x_ff;

   cpg_interp u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .t0     (ip_t0),
      .t1     (ip_t1),
      .z0     (top_z_ff),
      .z1     (bot_z_ff),
      .z      (depth_ff),
      .done   (ip_done),
      .result (ip_result)
   );

   always_comb begin
      cell_last = (slot_ff == cpg_pkg::LAST_SLOT);
      // Arithmetic shift right by 3 of the full sum; the floor always fits a coordinate.
      cen_x     = sum_x_ff[CB+2:3];
      cen_y     = sum_y_ff[CB+2:3];
      cen_z     = sum_z_ff[CB+2:3];
      if (active_ff && act_ff < cpg_pkg::ACT_W'(cpg_pkg::MAX_CELLS)) begin
         act_number = act_ff;
      end else begin
         act_number = '1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      top_x_in     = top_x_ff;
      top_y_in     = top_y_ff;
      top_z_in     = top_z_ff;
      bot_x_in     = bot_x_ff;
      bot_y_in     = bot_y_ff;
      bot_z_in     = bot_z_ff;
      depth_in     = depth_ff;
      active_in    = active_ff;
      flat_in      = flat_ff;
      axis_in      = axis_ff;
      start_in     = 1'b0;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      slot_in      = slot_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_z_in     = sum_z_ff;
      act_in       = act_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_flat_in  = rsp_flat_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_take) begin
               top_x_in  = in_tx;
               top_y_in  = in_ty;
               top_z_in  = in_tz;
               bot_x_in  = in_bx;
               bot_y_in  = in_by;
               bot_z_in  = in_bz;
               depth_in  = in_cz;
               active_in = req_tuser[0];
               flat_in   = (in_bz == in_tz);
               cx_in     = in_tx;
               cy_in     = in_ty;
               axis_in   = 1'b0;
               // A new grid restarts the cell walk before this corner is counted.
               if (req_tuser[1]) begin
                  slot_in  = '0;
                  sum_x_in = '0;
                  sum_y_in = '0;
                  sum_z_in = '0;
                  act_in   = '0;
               end
               if (in_bz == in_tz) begin
                  state_in = T_ACC;
               end else begin
                  start_in = 1'b1;
                  state_in = T_X;
               end
            end
         end
         T_X: begin
            if (ip_done) begin
               cx_in    = ip_result;
               axis_in  = 1'b1;
               start_in = 1'b1;
               state_in = T_Y;
            end
         end
         T_Y: begin
            if (ip_done) begin
               cy_in    = ip_result;
               state_in = T_ACC;
            end
         end
         T_ACC: begin
            sum_x_in = sum_x_ff + {{(cpg_pkg::SUM_W-CB){cx_ff[CB-1]}}, cx_ff};
            sum_y_in = sum_y_ff + {{(cpg_pkg::SUM_W-CB){cy_ff[CB-1]}}, cy_ff};
            sum_z_in = sum_z_ff + {{(cpg_pkg::SUM_W-CB){depth_ff[CB-1]}}, depth_ff};
            state_in = T_EMIT;
         end
         T_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flat_in  = flat_ff;
               rsp_last_in  = cell_last;
               if (cell_last) begin
                  rsp_data_in = cpg_pkg::RSP_DATA_W'({act_number, cen_z, cen_y, cen_x,
                                                      slot_ff, depth_ff, cy_ff, cx_ff});
                  sum_x_in    = '0;
                  sum_y_in    = '0;
                  sum_z_in    = '0;
                  slot_in     = '0;
                  if (active_ff && act_ff < cpg_pkg::ACT_W'(cpg_pkg::MAX_CELLS)) begin
                     act_in = act_ff + 1'b1;
                  end
               end else begin
                  rsp_data_in = cpg_pkg::RSP_DATA_W'({slot_ff, depth_ff, cy_ff, cx_ff});
                  slot_in     = slot_ff + 1'b1;
               end
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         act_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_z_ff     <= sum_z_in;
         act_ff       <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      top_x_ff    <= top_x_in;
      top_y_ff    <= top_y_in;
      top_z_ff    <= top_z_in;
      bot_x_ff    <= bot_x_in;
      bot_y_ff    <= bot_y_in;
      bot_z_ff    <= bot_z_in;
      depth_ff    <= depth_in;
      active_ff   <= active_in;
      flat_ff     <= flat_in;
      axis_ff     <= axis_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flat_ff <= rsp_flat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_flat_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule
